[rtl/lru_replacement_tracker_assert.svh]
// ----------------------------------------------------------------------------
// LRU replacement tracker assertion macros
// Concurrent checks clocked by aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef LRU_REPLACEMENT_TRACKER_ASSERT_SVH
`define LRU_REPLACEMENT_TRACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define LRT_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LRT_ASSERT(lbl, ante, cons, msg)
`define LRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/lrt_pkg.sv]
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared constants, codes and state type of the LRU replacement tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lrt_pkg;

    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 10;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;

    // stream payload widths, padded to whole bytes
    localparam int S_FIELDS_W = CMD_W + KEY_BITS;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STAT_W + KEY_BITS + 1 + CNT_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_MOVE   = 5'b00100,
        S_VREAD  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

endpackage

`default_nettype wire

[rtl/lrt_ram.sv]
// ----------------------------------------------------------------------------
// lrt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/lru_replacement_tracker.sv]
// ----------------------------------------------------------------------------
// lru_replacement_tracker: true LRU order over up to ENTRIES frame ids
// Insert and erase run a compare scan of the list, then a one-slot-per-cycle
// shift through the list RAM port; victim reads the last list slot. One item
// at a time: s_tready is high only when idle.
// Reset (aresetn low, synchronous) empties the list and drops any result.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_replacement_tracker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // s_tdata: command[1:0], frame_key[11:2], zero pad
    input  wire logic [lrt_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // m_tdata: status[1:0], victim_key[11:2], already_held[12],
    //          entry_count[17:13], zero pad
    output logic      [lrt_pkg::M_DATA_W-1:0] m_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready
);

    import lrt_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]      sr_idx_reg, sr_idx_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]      mv_addr_reg, mv_addr_next;
    logic [CNT_W-1:0]      mv_left_reg, mv_left_next;
    logic                  mv_up_reg, mv_up_next;
    logic                  grow_reg, grow_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      wr_addr_reg, wr_addr_next;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic [KEY_BITS-1:0]   victim_reg, victim_next;
    logic                  held_reg, held_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_wa;
    logic [KEY_BITS-1:0]   ram_wd;
    logic [IDX_W-1:0]      ram_ra;
    logic [KEY_BITS-1:0]   ram_rd;
    logic                  hit;

    lrt_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_list (
        .clk     (aclk),
        .we      (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the shared compare unit
    assign hit = cmp_vld_reg && (ram_rd == key_reg);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        sr_idx_next   = sr_idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        mv_addr_next  = mv_addr_reg;
        mv_left_next  = mv_left_reg;
        mv_up_next    = mv_up_reg;
        grow_next     = grow_reg;
        pend_next     = 1'b0;
        wr_addr_next  = wr_addr_reg;
        status_next   = status_reg;
        victim_next   = victim_reg;
        held_next     = held_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_wa        = wr_addr_reg;
        ram_wd        = ram_rd;
        ram_ra        = sr_idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next    = s_tdata[CMD_W-1:0];
                    key_next    = s_tdata[CMD_W +: KEY_BITS];
                    held_next   = 1'b0;
                    victim_next = '0;
                    status_next = ST_MISS;
                    sr_idx_next = '0;
                    grow_next   = 1'b0;
                    case (s_tdata[CMD_W-1:0])
                        CMD_INSERT, CMD_ERASE: begin
                            state_next = S_SEARCH;
                        end
                        CMD_VICTIM: begin
                            if (cnt_reg == '0) begin
                                state_next = S_DONE;
                            end else begin
                                ram_ra     = IDX_W'(cnt_reg - CNT_W'(1));
                                state_next = S_VREAD;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                // reads issue one slot a cycle; each read is compared in the next cycle
                if (sr_idx_reg < cnt_reg) begin
                    ram_ra       = sr_idx_reg[IDX_W-1:0];
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = sr_idx_reg[IDX_W-1:0];
                    sr_idx_next  = sr_idx_reg + CNT_W'(1);
                end
                if (hit) begin
                    cmp_vld_next = 1'b0;
                    status_next  = ST_OK;
                    state_next   = S_MOVE;
                    if (cmd_reg == CMD_INSERT) begin
                        held_next    = 1'b1;
                        mv_addr_next = cmp_idx_reg - IDX_W'(1);
                        mv_left_next = CNT_W'(cmp_idx_reg);
                        mv_up_next   = 1'b0;
                    end else begin
                        mv_addr_next = cmp_idx_reg + IDX_W'(1);
                        mv_left_next = cnt_reg - CNT_W'(1) - CNT_W'(cmp_idx_reg);
                        mv_up_next   = 1'b1;
                    end
                end else if (!cmp_vld_reg && !(sr_idx_reg < cnt_reg)) begin
                    if (cmd_reg != CMD_INSERT) begin
                        state_next = S_DONE;
                    end else if (cnt_reg == CNT_W'(ENTRIES)) begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end else begin
                        status_next  = ST_OK;
                        grow_next    = 1'b1;
                        mv_addr_next = IDX_W'(cnt_reg - CNT_W'(1));
                        mv_left_next = cnt_reg;
                        mv_up_next   = 1'b0;
                        state_next   = S_MOVE;
                    end
                end
            end

            S_MOVE: begin
                // read one slot, write it to its neighbor the next cycle
                if (pend_reg) begin
                    ram_we = 1'b1;
                    ram_wa = wr_addr_reg;
                    ram_wd = ram_rd;
                end
                if (mv_left_reg != '0) begin
                    ram_ra       = mv_addr_reg;
                    pend_next    = 1'b1;
                    mv_left_next = mv_left_reg - CNT_W'(1);
                    if (mv_up_reg) begin
                        wr_addr_next = mv_addr_reg - IDX_W'(1);
                        mv_addr_next = mv_addr_reg + IDX_W'(1);
                    end else begin
                        wr_addr_next = mv_addr_reg + IDX_W'(1);
                        mv_addr_next = mv_addr_reg - IDX_W'(1);
                    end
                end else if (!pend_reg) begin
                    if (cmd_reg == CMD_INSERT) begin
                        ram_we = 1'b1;
                        ram_wa = '0;
                        ram_wd = key_reg;
                        if (grow_reg) begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end else begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    state_next = S_DONE;
                end
            end

            S_VREAD: begin
                victim_next = ram_rd;
                status_next = ST_OK;
                cnt_next    = cnt_reg - CNT_W'(1);
                state_next  = S_DONE;
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({cnt_reg, held_reg, victim_reg, status_reg});
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        sr_idx_reg  <= sr_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        mv_addr_reg <= mv_addr_next;
        mv_left_reg <= mv_left_next;
        mv_up_reg   <= mv_up_next;
        grow_reg    <= grow_next;
        wr_addr_reg <= wr_addr_next;
        status_reg  <= status_next;
        victim_reg  <= victim_next;
        held_reg    <= held_next;
        m_tdata_reg <= m_tdata_next;
    end

`include "lru_replacement_tracker_assert.svh"

    `LRT_ASSERT(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(ENTRIES), "entry count above capacity")
    `LRT_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second transfer taken while busy")
    `LRT_ASSERT(a_held_ok, m_tvalid && m_tdata[STAT_W+KEY_BITS], m_tdata[STAT_W-1:0] == ST_OK, "touch hit without done status")
    `LRT_ASSERT(a_cnt_step, $past(aresetn) && (cnt_reg != $past(cnt_reg)), (cnt_reg == $past(cnt_reg) + CNT_W'(1)) || (cnt_reg == $past(cnt_reg) - CNT_W'(1)), "entry count moved by more than one")

endmodule

`default_nettype wire
